FILE: rtl/open_address_hash_table_macros.svh
// assertion macros for the open address hash table
// used by the top level; expects clk and rst_n in scope
`ifndef OPEN_ADDRESS_HASH_TABLE_MACROS_SVH
`define OPEN_ADDRESS_HASH_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define OAHT_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/oaht_pkg.sv
// shared types and constants for the open address hash table
// no dependencies
`timescale 1ns / 1ps

package oaht_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BYTES     = 8;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 16;
    localparam int SLOT_W  = 4;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
    localparam int LEN_W   = $clog2(KEY_BYTES + 1);

    // hash step product (h + b) * b and its reciprocal reduction
    localparam int PROD_MAX = (TABLE_ENTRIES - 1 + 255) * 255;
    localparam int PROD_W   = $clog2(PROD_MAX + 1);
    localparam logic [PROD_W-1:0] HASH_RECIP = PROD_W'((2 ** PROD_W) / TABLE_ENTRIES);

    // request codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    // slot status codes
    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_USED    = 2'd1;
    localparam logic [1:0] ST_DELETED = 2'd2;

    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // hash unit result toward the table controller
    typedef struct packed {
        logic               done;
        logic [IDX_W-1:0]   home;
        logic [KEY_W-1:0]   key;
    } hash_out_t;

endpackage

FILE: rtl/open_address_hash_table.sv
// open address hash table top level: request control, probe sequencer, slot memory
// depends on oaht_pkg, oaht_hash and open_address_hash_table_macros.svh
`timescale 1ns / 1ps

// open address hash table with linear probing and tombstones. a request is a
// transfer taken when start is high and busy is low; it inserts, looks up or
// deletes a key of up to eight bytes (first byte lowest, ended by the first
// zero byte). exactly one result comes back per request as a one-cycle pulse
// on done with ok, found_value and slot; there is no way to stall it, so the
// receiver must sample it on that cycle. busy stays high from the accepting
// edge until the edge that shows the result, so the next request can be
// taken on the cycle done is high. the hash unit works on each key byte in
// a multiply, a reciprocal and a reduce step, and the slot memory read port
// reads one slot per cycle along the probe path. an unknown request code
// probes nothing and answers as soon as the hash unit is done. after reset
// the block sweeps the slot memory to mark every slot empty, with busy high,
// before the first request.
module open_address_hash_table
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [oaht_pkg::KEY_W-1:0]    key,
    input  logic [oaht_pkg::VALUE_W-1:0]  value,
    output logic                          done,
    output logic                          ok,
    output logic [oaht_pkg::VALUE_W-1:0]  found_value,
    output logic [oaht_pkg::SLOT_W-1:0]   slot
);

`include "open_address_hash_table_macros.svh"

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_HASH, S_PROBE} state_t;

    localparam int N = oaht_pkg::TABLE_ENTRIES;
    localparam logic [oaht_pkg::IDX_W-1:0] LAST_IDX = oaht_pkg::IDX_W'(N - 1);
    localparam logic [oaht_pkg::CNT_W-1:0] FULL_CNT = oaht_pkg::CNT_W'(N);

    // control and result registers
    state_t                              state_reg, state_next;
    logic [1:0]                          action_reg, action_next;
    logic [oaht_pkg::VALUE_W-1:0]        value_reg, value_next;
    logic [oaht_pkg::IDX_W-1:0]          addr_reg, addr_next;
    logic [oaht_pkg::CNT_W-1:0]          issued_reg, issued_next;
    logic [oaht_pkg::CNT_W-1:0]          checked_reg, checked_next;
    logic                                rd_valid_reg, rd_valid_next;
    logic [oaht_pkg::IDX_W-1:0]          rd_addr_reg, rd_addr_next;
    logic                                done_reg, done_next;
    logic                                ok_reg, ok_next;
    logic [oaht_pkg::VALUE_W-1:0]        found_value_reg, found_value_next;
    logic [oaht_pkg::SLOT_W-1:0]         slot_reg, slot_next;

    // slot memory, one read and one write port, registered read data
    oaht_pkg::entry_t                    mem [N];
    oaht_pkg::entry_t                    rd_data_reg;
    logic                                mem_rd_en;
    logic [oaht_pkg::IDX_W-1:0]          mem_rd_addr;
    logic                                mem_wr_en;
    logic [oaht_pkg::IDX_W-1:0]          mem_wr_addr;
    oaht_pkg::entry_t                    mem_wr_data;

    // home slot and cut key
    logic                                hash_start;
    oaht_pkg::hash_out_t                 hash_res;

    oaht_hash u_hash
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (key),
        .result (hash_res)
    );

    logic                                accept;
    logic [oaht_pkg::IDX_W-1:0]          addr_inc;
    logic                                key_match;
    logic                                is_insert;
    logic                                is_search;

    assign accept    = start && (state_reg == S_IDLE);
    assign hash_start = accept;
    assign addr_inc  = (addr_reg == LAST_IDX) ? '0 : addr_reg + oaht_pkg::IDX_W'(1);
    assign key_match = (rd_data_reg.key == hash_res.key);
    assign is_insert = (action_reg == oaht_pkg::ACT_INSERT);
    assign is_search = (action_reg == oaht_pkg::ACT_LOOKUP)
                       || (action_reg == oaht_pkg::ACT_DELETE);

    always_comb
    begin
        state_next       = state_reg;
        action_next      = action_reg;
        value_next       = value_reg;
        addr_next        = addr_reg;
        issued_next      = issued_reg;
        checked_next     = checked_reg;
        rd_valid_next    = 1'b0;
        rd_addr_next     = rd_addr_reg;
        done_next        = 1'b0;
        ok_next          = ok_reg;
        found_value_next = found_value_reg;
        slot_next        = slot_reg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = addr_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = addr_reg;
        mem_wr_data      = rd_data_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // sweep every slot to empty
                mem_wr_en          = 1'b1;
                mem_wr_data.status = oaht_pkg::ST_EMPTY;
                mem_wr_data.key    = '0;
                mem_wr_data.value  = '0;
                addr_next          = addr_inc;
                if (addr_reg == LAST_IDX)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next = action;
                    value_next  = value;
                    state_next  = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_res.done)
                begin
                    if (is_insert || is_search)
                    begin
                        addr_next    = hash_res.home;
                        issued_next  = '0;
                        checked_next = '0;
                        state_next   = S_PROBE;
                    end
                    else
                    begin
                        // unknown request: nothing changes
                        done_next        = 1'b1;
                        ok_next          = 1'b0;
                        found_value_next = '0;
                        slot_next        = '0;
                        state_next       = S_IDLE;
                    end
                end
            end
            S_PROBE:
            begin
                // issue one read per cycle along the probe path
                if (issued_reg != FULL_CNT)
                begin
                    mem_rd_en     = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_addr_next  = addr_reg;
                    addr_next     = addr_inc;
                    issued_next   = issued_reg + oaht_pkg::CNT_W'(1);
                end

                // check the slot read last cycle
                if (rd_valid_reg)
                begin
                    checked_next = checked_reg + oaht_pkg::CNT_W'(1);
                    mem_wr_addr  = rd_addr_reg;
                    if (is_insert && rd_data_reg.status != oaht_pkg::ST_USED)
                    begin
                        // first empty or deleted slot takes the key
                        mem_wr_en          = 1'b1;
                        mem_wr_data.status = oaht_pkg::ST_USED;
                        mem_wr_data.key    = hash_res.key;
                        mem_wr_data.value  = value_reg;
                        done_next          = 1'b1;
                        ok_next            = 1'b1;
                        found_value_next   = '0;
                        slot_next          = oaht_pkg::SLOT_W'(rd_addr_reg);
                    end
                    else if (is_search && rd_data_reg.status == oaht_pkg::ST_EMPTY)
                    begin
                        // empty slot ends the search
                        done_next        = 1'b1;
                        ok_next          = 1'b0;
                        found_value_next = '0;
                        slot_next        = '0;
                    end
                    else if (is_search && rd_data_reg.status == oaht_pkg::ST_USED && key_match)
                    begin
                        if (action_reg == oaht_pkg::ACT_DELETE)
                        begin
                            mem_wr_en          = 1'b1;
                            mem_wr_data.status = oaht_pkg::ST_DELETED;
                        end
                        done_next        = 1'b1;
                        ok_next          = 1'b1;
                        found_value_next = rd_data_reg.value;
                        slot_next        = oaht_pkg::SLOT_W'(rd_addr_reg);
                    end
                    else if (checked_reg + oaht_pkg::CNT_W'(1) == FULL_CNT)
                    begin
                        // whole table walked without a match or a free slot
                        done_next        = 1'b1;
                        ok_next          = 1'b0;
                        found_value_next = '0;
                        slot_next        = '0;
                    end
                end

                // a read still in flight at the end is simply dropped
                if (done_next)
                begin
                    rd_valid_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            action_reg      <= oaht_pkg::ACT_INSERT;
            value_reg       <= '0;
            addr_reg        <= '0;
            issued_reg      <= '0;
            checked_reg     <= '0;
            rd_valid_reg    <= 1'b0;
            rd_addr_reg     <= '0;
            done_reg        <= 1'b0;
            ok_reg          <= 1'b0;
            found_value_reg <= '0;
            slot_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            action_reg      <= action_next;
            value_reg       <= value_next;
            addr_reg        <= addr_next;
            issued_reg      <= issued_next;
            checked_reg     <= checked_next;
            rd_valid_reg    <= rd_valid_next;
            rd_addr_reg     <= rd_addr_next;
            done_reg        <= done_next;
            ok_reg          <= ok_next;
            found_value_reg <= found_value_next;
            slot_reg        <= slot_next;
        end
    end

    // slot memory; apart from the reset sweep, writes happen only on the last
    // probe cycle of a request and the next request reads no earlier than the
    // following cycle, so no forwarding path is needed
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            rd_data_reg <= mem[mem_rd_addr];
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign found_value = found_value_reg;
    assign slot        = slot_reg;

    // checks
    `OAHT_ASSERT(a_fail_zero, done_reg && !ok_reg,
        found_value_reg == '0 && slot_reg == '0, "failed result not zeroed")
    `OAHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
        "request accepted but block not busy")
    `OAHT_ASSERT(a_write_place, mem_wr_en,
        state_reg == S_CLEAR || (state_reg == S_PROBE && rd_valid_reg),
        "slot write outside sweep or probe check")
    `OAHT_ASSERT(a_probe_order, state_reg == S_PROBE,
        checked_reg <= issued_reg && issued_reg <= FULL_CNT,
        "probe counters out of order")
    `OAHT_ASSERT(a_done_origin, done_reg,
        $past(state_reg) == S_PROBE || $past(state_reg) == S_HASH,
        "result without a request in flight")

endmodule

FILE: rtl/oaht_hash.sv
// key cut and iterative home slot hash, one key byte at a time
// depends on oaht_pkg
`timescale 1ns / 1ps

module oaht_hash
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [oaht_pkg::KEY_W-1:0]    key,
    output oaht_pkg::hash_out_t           result
);

    typedef enum logic [1:0] {H_IDLE, H_MUL, H_RECIP, H_REDUCE} hstate_t;

    hstate_t                             state_reg, state_next;
    logic [oaht_pkg::KEY_W-1:0]          kept_reg, kept_next;
    logic [oaht_pkg::KEY_W-1:0]          shift_reg, shift_next;
    logic [oaht_pkg::LEN_W-1:0]          cnt_reg, cnt_next;
    logic [oaht_pkg::IDX_W-1:0]          h_reg, h_next;
    logic [oaht_pkg::PROD_W-1:0]         p_reg, p_next;
    logic [oaht_pkg::PROD_W-1:0]         q_reg, q_next;
    logic                                done_reg, done_next;

    // key cut: bytes up to the first zero byte or KEY_BYTES bytes
    logic [oaht_pkg::KEY_W-1:0]          cut_key;
    logic [oaht_pkg::LEN_W-1:0]          cut_len;
    logic                                alive;

    always_comb
    begin
        cut_key = '0;
        cut_len = '0;
        alive   = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (i >= oaht_pkg::KEY_BYTES || key[i*8 +: 8] == 8'd0)
                alive = 1'b0;
            if (alive)
            begin
                cut_key[i*8 +: 8] = key[i*8 +: 8];
                cut_len           = cut_len + oaht_pkg::LEN_W'(1);
            end
        end
    end

    logic [7:0]                          cur_byte;
    logic [2*oaht_pkg::PROD_W-1:0]       recip_prod;
    logic [oaht_pkg::PROD_W-1:0]         rem_raw;
    logic [oaht_pkg::PROD_W-1:0]         rem_fix;

    assign cur_byte   = shift_reg[7:0];
    assign recip_prod = (2*oaht_pkg::PROD_W)'(p_reg) * (2*oaht_pkg::PROD_W)'(oaht_pkg::HASH_RECIP);
    assign rem_raw    = p_reg - oaht_pkg::PROD_W'(q_reg * oaht_pkg::PROD_W'(oaht_pkg::TABLE_ENTRIES));
    assign rem_fix    = (rem_raw >= oaht_pkg::PROD_W'(oaht_pkg::TABLE_ENTRIES))
                        ? rem_raw - oaht_pkg::PROD_W'(oaht_pkg::TABLE_ENTRIES) : rem_raw;

    always_comb
    begin
        state_next = state_reg;
        kept_next  = kept_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        h_next     = h_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    kept_next  = cut_key;
                    shift_next = cut_key;
                    cnt_next   = cut_len;
                    h_next     = '0;
                    if (cut_len == '0)
                        done_next = 1'b1;
                    else
                        state_next = H_MUL;
                end
            end
            H_MUL:
            begin
                p_next = oaht_pkg::PROD_W'((oaht_pkg::PROD_W'(h_reg) + oaht_pkg::PROD_W'(cur_byte))
                                           * oaht_pkg::PROD_W'(cur_byte));
                state_next = H_RECIP;
            end
            H_RECIP:
            begin
                // quotient estimate, low by at most one
                q_next     = recip_prod[2*oaht_pkg::PROD_W-1 -: oaht_pkg::PROD_W];
                state_next = H_REDUCE;
            end
            H_REDUCE:
            begin
                h_next     = oaht_pkg::IDX_W'(rem_fix);
                shift_next = shift_reg >> 8;
                cnt_next   = cnt_reg - oaht_pkg::LEN_W'(1);
                if (cnt_reg == oaht_pkg::LEN_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                    state_next = H_MUL;
            end
            default:
                state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
            h_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            h_reg     <= h_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kept_reg  <= kept_next;
        shift_reg <= shift_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
    end

    assign result.done = done_reg;
    assign result.home = h_reg;
    assign result.key  = kept_reg;

endmodule
